[hdl/grr_pkg.sv]
// Package for the group reverse reorder block: payload words, control structs
// and fixed widths. It has no dependencies of its own.
package grr_pkg;

  // Fixed field widths of the payload and the configuration register.
  localparam int unsigned DataW     = 32;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned MaxGroup  = 16;

  // Input word: one element and the end-of-sequence flag.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    final_element;
  } in_word_t;

  // Output word: one reordered element and its markers.
  typedef struct packed {
    logic signed [DataW-1:0] out_value;
    logic                    run_last;
    logic                    sequence_end;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input word into the buffer
    logic start;   // begin draining the buffered group
    logic issue;   // read one buffered element toward the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush;       // the incoming word completes a group or ends the sequence
    logic last_issue;  // the next read is the last one of the group
    logic out_free;    // the output stage can take a new word this cycle
  } stat_t;

endpackage

[hdl/grr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the group buffer.
module grr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/grr_ctrl.sv]
// Controller for the group reverse reorder block: fill and drain sequencing.
// Depends on grr_pkg for the command and status structs.
module grr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  grr_pkg::stat_t stat_i,
  output grr_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;

  // Words are taken only while filling; draining owns the buffer read side.
  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    cmd_o.accept = (state_q == ST_FILL) && in_valid_i;
    cmd_o.start  = cmd_o.accept && stat_i.flush;
    cmd_o.issue  = (state_q == ST_DRAIN) && stat_i.out_free;
    unique case (state_q)
      ST_FILL: begin
        if (cmd_o.start) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd_o.issue && stat_i.last_issue) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  assign in_stall_o = (state_q != ST_FILL);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/grr_dp.sv]
// Datapath for the group reverse reorder block: group buffer, fill count,
// drain pointer and output stage. Depends on grr_pkg and grr_ram.
module grr_dp #(
  parameter int unsigned MaxGroup = grr_pkg::MaxGroup
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [grr_pkg::CfgW-1:0]   cfg_data_i,
  input  grr_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output grr_pkg::out_word_t         out_word_o,
  input  grr_pkg::cmd_t              cmd_i,
  output grr_pkg::stat_t             stat_o
);

  localparam int unsigned AddrW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;
  localparam int unsigned CntW  = $clog2(MaxGroup + 1);
  localparam int unsigned CmpW  = (CntW > grr_pkg::CfgW) ? CntW : grr_pkg::CfgW;

  logic [grr_pkg::CfgW-1:0] group_size_q;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [CntW-1:0]          remain_q, remain_d;
  logic [AddrW-1:0]         ptr_q, ptr_d;
  logic                     rev_q, rev_d;
  logic                     seq_fin_q, seq_fin_d;
  logic                     pend_q, pend_d;
  logic                     run_last_q, run_last_d;
  logic                     seq_end_q, seq_end_d;

  logic [CmpW-1:0]          k_ext;
  logic [CntW-1:0]          k_eff;
  logic [CntW-1:0]          fill_sat;
  logic [CntW-1:0]          n_cnt;
  logic                     group_done;
  logic [grr_pkg::DataW-1:0] rdata;

  // Config register: user writes only while the block is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= grr_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      group_size_q <= cfg_data_i;
    end
  end

  // Effective group size: zero acts as one, oversize saturates to the depth.
  always_comb begin
    k_ext = CmpW'(group_size_q);
    if (k_ext == '0) begin
      k_ext = CmpW'(1);
    end
    if (k_ext > CmpW'(MaxGroup)) begin
      k_ext = CmpW'(MaxGroup);
    end
    k_eff = CntW'(k_ext);
  end

  // Write slot and count after the incoming word.
  assign fill_sat   = (fill_q >= CntW'(MaxGroup)) ? CntW'(MaxGroup - 1) : fill_q;
  assign n_cnt      = fill_sat + CntW'(1);
  assign group_done = (n_cnt >= k_eff);

  assign stat_o.flush      = group_done || in_word_i.final_element;
  assign stat_o.last_issue = (remain_q == CntW'(1));
  assign stat_o.out_free   = !pend_q || !out_stall_i;

  // Group buffer.
  grr_ram #(
    .Width (grr_pkg::DataW),
    .Depth (MaxGroup)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (AddrW'(fill_sat)),
    .wdata_i (in_word_i.value),
    .re_i    (cmd_i.issue),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // Fill count, drain pointer and output stage sequencing.
  always_comb begin
    fill_d     = fill_q;
    remain_d   = remain_q;
    ptr_d      = ptr_q;
    rev_d      = rev_q;
    seq_fin_d  = seq_fin_q;
    run_last_d = run_last_q;
    seq_end_d  = seq_end_q;
    pend_d     = pend_q && out_stall_i;
    if (cmd_i.accept) begin
      fill_d = cmd_i.start ? '0 : n_cnt;
    end
    if (cmd_i.start) begin
      remain_d  = n_cnt;
      rev_d     = group_done;
      seq_fin_d = in_word_i.final_element;
      ptr_d     = group_done ? AddrW'(n_cnt - CntW'(1)) : '0;
    end
    if (cmd_i.issue) begin
      remain_d   = remain_q - CntW'(1);
      ptr_d      = rev_q ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
      run_last_d = (remain_q == CntW'(1));
      seq_end_d  = (remain_q == CntW'(1)) && seq_fin_q;
      pend_d     = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      remain_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      remain_q <= remain_d;
      pend_q   <= pend_d;
    end
  end

  // Drain pointer and markers travel with the data and need no reset.
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    rev_q      <= rev_d;
    seq_fin_q  <= seq_fin_d;
    run_last_q <= run_last_d;
    seq_end_q  <= seq_end_d;
  end

  assign out_valid_o             = pend_q;
  assign out_word_o.out_value    = rdata;
  assign out_word_o.run_last     = run_last_q;
  assign out_word_o.sequence_end = seq_end_q;

`ifndef SYNTHESIS
  // The fill count never reaches the buffer depth between items.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CntW'(MaxGroup))
    else $error("fill count reached the buffer depth");

  // A read is issued only while elements of the group remain.
  a_issue_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> remain_q != '0)
    else $error("buffer read issued with nothing left to drain");

  // Every issued read shows up as an output word in the next cycle.
  a_issue_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> pend_q)
    else $error("issued read did not reach the output stage");

  // A sequence end always closes a run.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && seq_end_q |-> run_last_q)
    else $error("sequence end without run last");
`endif

endmodule

[hdl/group_reverse_reorder.sv]
// Top level of the group reverse reorder block: joins controller and datapath.
// Depends on grr_pkg, grr_ctrl, grr_dp and grr_ram.
//
// Usage: words enter on the input channel (in_valid_i, in_stall_o, in_word_i),
// one element each, with final_element set on the last one of a sequence.
// Results leave on the output channel (out_valid_o, out_stall_i, out_word_o).
// Each word that completes a group of group_size elements drains that group in
// reverse order; a final word that leaves a partial group drains it in
// arrival order. Every other word produces no output.
// After the accepting edge the controller enters the drain state; the first
// word of the group is then read from the buffer into the registered output.
// The input takes one word per cycle while the buffer fills, then stalls while
// the group drains at one word per cycle as long as the output does not stall.
// Fill and drain take turns, since the single buffer memory is written during
// fill and read during drain.
// A stalled output holds its word and pauses the drain; the next input word
// can be accepted while the last word of a group still waits.
// Reset clears the fill count and the state and sets group_size to 1;
// buffer contents are not cleared. The user writes group_size through cfg_we_i
// and cfg_data_i only while the block is idle; the block does not enforce it.
module group_reverse_reorder #(
  parameter int unsigned MaxGroup = grr_pkg::MaxGroup
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [grr_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  grr_pkg::in_word_t        in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output grr_pkg::out_word_t       out_word_o
);

  grr_pkg::cmd_t  cmd;
  grr_pkg::stat_t stat;

  // Sequencing of fill and drain.
  grr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Buffer, counters and output stage.
  grr_dp #(
    .MaxGroup (MaxGroup)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
